@@ sv/mqe_pkg.sv @@
`timescale 1ns / 1ps
// Package for the multi quadrature encoder scanner.
// Shared constants, direction and mode codes, and the lane result struct.
package mqe_pkg;

  localparam int NUM_ENCODERS = 6;
  localparam int PIN_W        = 12;
  localparam int ENC_W        = 3;
  localparam int DIR_W        = 2;
  localparam int CFG_W        = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int LANE_IDX_W   = $clog2(NUM_ENCODERS + 1) > ENC_W ?
                                $clog2(NUM_ENCODERS + 1) : ENC_W;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

  localparam logic MODE_SCAN    = 1'b0;
  localparam logic MODE_CAPTURE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = 1'b1;

  localparam logic [1:0] PH_00 = 2'b00;
  localparam logic [1:0] PH_01 = 2'b01;
  localparam logic [1:0] PH_10 = 2'b10;
  localparam logic [1:0] PH_11 = 2'b11;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic             take;
  } lane_res_t;

endpackage

@@ sv/mqe_lane.sv @@
`timescale 1ns / 1ps
// One encoder lane: stored phase pair and its transition decode.
// Depends on mqe_pkg.
module mqe_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        pair,
  input  logic              load,
  output mqe_pkg::lane_res_t res
);
  import mqe_pkg::*;

  logic [1:0] phase_r;

  always_comb begin
    res.dir  = DIR_NONE;
    res.take = 1'b0;
    case (phase_r)
      PH_00: begin
        if (pair == PH_01) begin
          res.dir  = DIR_CW;
          res.take = 1'b1;
        end else if (pair == PH_10) begin
          res.dir  = DIR_CCW;
          res.take = 1'b1;
        end
      end
      PH_11: begin
        if (pair == PH_10) begin
          res.dir  = DIR_CW;
          res.take = 1'b1;
        end else if (pair == PH_01) begin
          res.dir  = DIR_CCW;
          res.take = 1'b1;
        end
      end
      default: begin
        res.take = (pair == PH_00) || (pair == PH_11);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_00;
    end else if (load) begin
      phase_r <= pair;
    end
  end

endmodule

@@ sv/mqe_merge.sv @@
`timescale 1ns / 1ps
// Priority merge of lane results: first moving encoder in range wins.
// Depends on mqe_pkg.
module mqe_merge (
  input  mqe_pkg::lane_res_t                 res [mqe_pkg::NUM_ENCODERS],
  input  logic [mqe_pkg::NUM_ENCODERS-1:0]   in_range,
  output logic [mqe_pkg::NUM_ENCODERS-1:0]   upd,
  output logic [mqe_pkg::ENC_W-1:0]          enc_num,
  output logic [mqe_pkg::DIR_W-1:0]          dir
);
  import mqe_pkg::*;

  logic found;

  always_comb begin
    found   = 1'b0;
    enc_num = '0;
    dir     = DIR_NONE;
    upd     = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      upd[i] = in_range[i] && res[i].take && !found;
      if (!found && in_range[i] && (res[i].dir != DIR_NONE)) begin
        found   = 1'b1;
        enc_num = ENC_W'(i + 1);
        dir     = res[i].dir;
      end
    end
  end

endmodule

@@ sv/multi_quadrature_encoder_scan.sv @@
`timescale 1ns / 1ps
// Multi quadrature encoder scanner, top level. Depends on mqe_pkg, mqe_lane, mqe_merge.
// The result is registered and presented in the cycle after the input transfer.
// Throughput: one item per cycle while in_stall is low; all lanes decode and update in parallel.
// Input stalls only while a held result is stalled at the output.
// Reset: all encoder pairs 00, first_encoder 1, last_encoder 6, no result pending.
module multi_quadrature_encoder_scan (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mqe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mqe_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [mqe_pkg::PIN_W-1:0]       in_pin_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mqe_pkg::ENC_W-1:0]       out_encoder_number,
  output logic [mqe_pkg::DIR_W-1:0]       out_direction
);
  import mqe_pkg::*;

  logic [CFG_W-1:0]        first_r;
  logic [CFG_W-1:0]        last_r;
  logic                    out_valid_r;
  logic [ENC_W-1:0]        enc_r;
  logic [DIR_W-1:0]        dir_r;
  logic                    in_xfer;
  logic                    capture;
  logic [NUM_ENCODERS-1:0] in_range;
  logic [NUM_ENCODERS-1:0] upd;
  logic [ENC_W-1:0]        enc_nxt;
  logic [DIR_W-1:0]        dir_nxt;
  lane_res_t               res [NUM_ENCODERS];

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign capture  = (in_mode == MODE_CAPTURE);

  for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_lane
    localparam int LO = 2 * i;
    logic [1:0] pair;
    logic       load;

    if (LO + 1 < PIN_W) begin : g_full
      assign pair = in_pin_word[LO +: 2];
    end else if (LO < PIN_W) begin : g_half
      assign pair = {1'b0, in_pin_word[LO]};
    end else begin : g_none
      assign pair = 2'b00;
    end

    assign in_range[i] = (LANE_IDX_W'(i + 1) >= LANE_IDX_W'(first_r)) &&
                         (LANE_IDX_W'(i + 1) <= LANE_IDX_W'(last_r));
    assign load = in_xfer && (capture || upd[i]);

    mqe_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .pair  (pair),
      .load  (load),
      .res   (res[i])
    );
  end

  mqe_merge u_merge (
    .res      (res),
    .in_range (in_range),
    .upd      (upd),
    .enc_num  (enc_nxt),
    .dir      (dir_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= CFG_W'(1);
      last_r  <= CFG_W'(6);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST: first_r <= cfg_wdata;
        REG_LAST:  last_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      enc_r <= capture ? '0 : enc_nxt;
      dir_r <= capture ? DIR_NONE : dir_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_encoder_number = enc_r;
  assign out_direction      = dir_r;

endmodule

@@ dv/tb_multi_quadrature_encoder_scan.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_quadrature_encoder_scan: directed table, then phased random
// quadrature traffic under several scan ranges and idle mixes. Depends on mqe_pkg and the RTL.
module tb_multi_quadrature_encoder_scan;
  import mqe_pkg::*;

  localparam int ITEMS_PER_PHASE = 120;
  localparam int NUM_PHASES      = 16;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic [ENC_W-1:0] enc;
    logic [DIR_W-1:0] dir;
  } motion_t;

  localparam motion_t NO_MOTION = '{enc: '0, dir: DIR_NONE};

  typedef enum logic [1:0] {STEP_PREDICTED, STEP_TYPED, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic                   mode;
    logic [PIN_W-1:0]       pins;
    motion_t                want;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_val;
  } step_t;

  localparam logic [CFG_W-1:0] SWEEP_FIRST [8] = '{3'd1, 3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd2, 3'd5};
  localparam logic [CFG_W-1:0] SWEEP_LAST  [8] = '{3'd6, 3'd7, 3'd0, 3'd1, 3'd6, 3'd5, 3'd4, 3'd2};

  step_t directed_steps [32] = '{
    '{STEP_TYPED,     MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h001, '{3'd1, DIR_CW},      REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h002, '{3'd1, DIR_CCW},     REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h003, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h001, '{3'd1, DIR_CCW},     REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h003, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h002, '{3'd1, DIR_CW},      REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h003, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_CAPTURE, 12'hFFF, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_PREDICTED, MODE_SCAN,    12'h800, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_PREDICTED, MODE_SCAN,    12'h555, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_PREDICTED, MODE_SCAN,    12'h555, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_CAPTURE, 12'h000, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_PREDICTED, MODE_SCAN,    12'h555, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_PREDICTED, MODE_SCAN,    12'hAAA, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_CFG,       MODE_SCAN,    12'h000, NO_MOTION,            REG_LAST,  3'd0},
    '{STEP_TYPED,     MODE_SCAN,    12'h555, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_CFG,       MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd7},
    '{STEP_CFG,       MODE_SCAN,    12'h000, NO_MOTION,            REG_LAST,  3'd7},
    '{STEP_TYPED,     MODE_SCAN,    12'hFFF, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_CFG,       MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_CFG,       MODE_SCAN,    12'h000, NO_MOTION,            REG_LAST,  3'd6},
    '{STEP_PREDICTED, MODE_SCAN,    12'hC00, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_CFG,       MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd6},
    '{STEP_PREDICTED, MODE_SCAN,    12'h400, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_TYPED,     MODE_CAPTURE, 12'hABC, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_PREDICTED, MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd0},
    '{STEP_CFG,       MODE_SCAN,    12'h000, NO_MOTION,            REG_FIRST, 3'd1},
    '{STEP_PREDICTED, MODE_SCAN,    12'h5A5, NO_MOTION,            REG_FIRST, 3'd0}
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_mode = MODE_SCAN;
  logic [PIN_W-1:0]     in_pin_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ENC_W-1:0]     out_encoder_number;
  logic [DIR_W-1:0]     out_direction;

  logic [1:0]           phase_q [NUM_ENCODERS] = '{default: PH_00};
  logic [CFG_W-1:0]     first_enc = 3'd1;
  logic [CFG_W-1:0]     last_enc  = 3'd6;
  motion_t              motion_q [$];
  logic                 item_typed = 1'b0;
  motion_t              item_want = '0;
  int                   sender_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  logic [PIN_W-1:0]     shaft_pins = '0;

  multi_quadrature_encoder_scan uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_pin_word        (in_pin_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_encoder_number (out_encoder_number),
    .out_direction      (out_direction)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic motion_t predict_motion(input logic m, input logic [PIN_W-1:0] pins);
    motion_t          r;
    logic [1:0]       was;
    logic [1:0]       now;
    logic [DIR_W-1:0] d;
    logic             take;
    r = NO_MOTION;
    if (m == MODE_CAPTURE) begin
      for (int k = 1; k <= NUM_ENCODERS; k++) phase_q[k-1] = pins[2*k-2 +: 2];
      return r;
    end
    for (int k = 1; k <= NUM_ENCODERS; k++) begin
      if (k < first_enc || k > last_enc) continue;
      was  = phase_q[k-1];
      now  = pins[2*k-2 +: 2];
      d    = DIR_NONE;
      take = 1'b0;
      case (was)
        PH_00: begin
          if (now == PH_01) d = DIR_CW;
          else if (now == PH_10) d = DIR_CCW;
        end
        PH_11: begin
          if (now == PH_10) d = DIR_CW;
          else if (now == PH_01) d = DIR_CCW;
        end
        default: take = (now == PH_00 || now == PH_11);
      endcase
      if (d != DIR_NONE || take) phase_q[k-1] = now;
      if (d != DIR_NONE) begin
        r.enc = ENC_W'(k);
        r.dir = d;
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multi_quadrature_encoder_scan test failed");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin
    motion_t pred;
    motion_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = predict_motion(in_mode, in_pin_word);
        motion_q.push_back(item_typed ? item_want : pred);
      end
      if (out_valid && !out_stall) begin
        if (motion_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transfer: encoder %0d direction %0d",
                     out_encoder_number, out_direction);
        end else begin
          want = motion_q.pop_front();
          if (out_encoder_number !== want.enc || out_direction !== want.dir) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: encoder exp %0d got %0d, direction exp %0d got %0d",
                       want.enc, out_encoder_number, want.dir, out_direction);
          end
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic transfer_item(input logic m, input logic [PIN_W-1:0] p,
                               input logic typed, input motion_t want_m);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_pin_word <= p;
    item_typed  = typed;
    item_want   = want_m;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (motion_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIRST) first_enc = val;
    else last_enc = val;
  endtask

  initial begin
    int               pick;
    int               bit_idx;
    logic             m;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG)
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      else
        transfer_item(directed_steps[i].mode, directed_steps[i].pins,
                      directed_steps[i].kind == STEP_TYPED, directed_steps[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 8) begin
        lo = SWEEP_FIRST[ph];
        hi = SWEEP_LAST[ph];
      end else begin
        lo = CFG_W'($urandom_range(1, 3));
        hi = CFG_W'($urandom_range(3, 6));
      end
      write_reg(REG_FIRST, lo);
      write_reg(REG_LAST, hi);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        m    = MODE_SCAN;
        if (pick < 70) begin
          // one or two single-bit toggles, each on a randomly chosen encoder
          repeat ($urandom_range(1, 2)) begin
            bit_idx = 2 * ($urandom_range(1, NUM_ENCODERS) - 1) + $urandom_range(0, 1);
            shaft_pins[bit_idx] = ~shaft_pins[bit_idx];
          end
        end else if (pick < 78) begin
          shaft_pins = shaft_pins;
        end else if (pick < 86) begin
          m          = MODE_CAPTURE;
          shaft_pins = PIN_W'($urandom());
        end else begin
          shaft_pins = PIN_W'($urandom());
        end
        transfer_item(m, shaft_pins, 1'b0, NO_MOTION);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("multi_quadrature_encoder_scan test passed");
    end else begin
      $display("multi_quadrature_encoder_scan test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mqe_pkg.sv
sv/mqe_lane.sv
sv/mqe_merge.sv
sv/multi_quadrature_encoder_scan.sv
dv/tb_multi_quadrature_encoder_scan.sv
